>>> src/transpose_self_organizing_list_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the transpose self-organising list
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TRANSPOSE_SELF_ORGANIZING_LIST_DEFINES_SVH
`define TRANSPOSE_SELF_ORGANIZING_LIST_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TSOL_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TSOL_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tsol_pkg.sv
// ----------------------------------------------------------------------------
// Transpose self-organising list package
// Field widths, operation and status codes, state and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsol_pkg;

   // Payload field widths.
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   // Operation codes.
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // Controller states.
   typedef enum logic {
      FSM_IDLE,
      FSM_UPDATE
   } state_type;

   // Commands broadcast to every cell during the update cycle.
   typedef struct packed {
      logic transpose;
      logic append;
      logic remove;
   } cell_ctrl_type;

endpackage

>>> src/tsol_if.sv
// ----------------------------------------------------------------------------
// Transpose self-organising list channels
// Valid/ready request and response channels with source and sink views.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsol_req_if;
   logic                       valid;
   logic                       ready;
   logic [tsol_pkg::ACTION_W-1:0] action;
   logic signed [tsol_pkg::KEY_W-1:0] key;

   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

interface tsol_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tsol_pkg::STATUS_W-1:0] status;
   logic [tsol_pkg::POS_W-1:0]    position;
   logic [tsol_pkg::COUNT_W-1:0]  entry_count;
   logic                          is_empty;

   modport source (output valid, output status, output position, output entry_count,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input position, input entry_count,
                   input is_empty, output ready);
endinterface

>>> src/tsol_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry, flags a key match and swaps or shifts with its
// neighbours when the controller commits an operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsol_cell #(
   parameter int INDEX    = 0,
   parameter int CAPACITY = 16
) (
   input  logic                                  clock,
   input  logic [tsol_pkg::KEY_W-1:0]            key,
   input  logic [$clog2(CAPACITY+1)-1:0]         count,
   input  logic                                  capture,
   input  tsol_pkg::cell_ctrl_type               ctrl,
   input  logic [tsol_pkg::KEY_W-1:0]            left_entry,
   input  logic [tsol_pkg::KEY_W-1:0]            right_entry,
   input  logic                                  right_match,
   input  logic                                  hit_in,
   input  logic [$clog2(CAPACITY)-1:0]           pos_in,
   output logic [tsol_pkg::KEY_W-1:0]            entry,
   output logic                                  match,
   output logic                                  hit_out,
   output logic [$clog2(CAPACITY)-1:0]           pos_out
);
   import tsol_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [KEY_W-1:0] entry_ff, entry_in;
   logic             match_ff, match_in;

   // A cell only matches when it lies inside the occupied part of the list.
   assign match_in = (key == entry_ff) && (CW'(INDEX) < count);

   always_ff @(posedge clock) begin
      if (capture) begin
         match_ff <= match_in;
      end
   end

   // Hit and position ripple towards the tail; the matching cell adds its index.
   assign hit_out = hit_in | match_ff;
   assign pos_out = pos_in | (match_ff ? IW'(INDEX) : {IW{1'b0}});

   // Entry update: swap with a neighbour, close the gap after a removal or take
   // the new key at the tail.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.transpose) begin
         if (match_ff && (INDEX != 0)) begin
            entry_in = left_entry;
         end else if (right_match) begin
            entry_in = right_entry;
         end
      end
      if (ctrl.remove && hit_out) begin
         entry_in = right_entry;
      end
      if (ctrl.append && (count == CW'(INDEX))) begin
         entry_in = key;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

>>> src/transpose_self_organizing_list.sv
// Flow: the cell row compares the key as a transaction is taken in the idle state; in the
// update state every cell swaps, shifts or loads and the response is registered. No new
// transaction is taken until then; the update waits while a response is held.
// Reset: synchronous, clears the entry count, the controller and the response valid; the
// entry registers are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
// Transpose self-organising list
// Ordered list of distinct keys held in a row of cells; a search moves the
// found or duplicate key one place forward, inserts append at the tail, removes close up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module transpose_self_organizing_list #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   tsol_req_if.sink   req_bus,
   tsol_rsp_if.source rsp_bus
);
   import tsol_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   state_type             state_ff, state_in;
   logic [ACTION_W-1:0]   action_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [KEY_W-1:0]      key_sel;
   logic [CW-1:0]         count_ff, count_in;
   logic                  req_ready;
   logic                  capture;
   logic                  commit;
   logic                  out_free;
   cell_ctrl_type         ctrl;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [POS_W-1:0]      position_ff, position_in;
   logic [COUNT_W-1:0]    entry_count_ff;
   logic                  is_empty_ff;

   logic [KEY_W-1:0]      entry_bus [CAPACITY];
   logic                  match_bus [CAPACITY];
   logic                  hit_chain [CAPACITY+1];
   logic [IW-1:0]         pos_chain [CAPACITY+1];
   logic                  found;
   logic [IW-1:0]         hit_pos;

   // Handshake terms.
   assign capture  = req_bus.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (capture) begin
               state_in = FSM_UPDATE;
            end
         end
         FSM_UPDATE: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
         end
         FSM_UPDATE: begin
            commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // The cells compare against the incoming key at acceptance and load the
   // held key on an append.
   assign key_sel = (state_ff == FSM_IDLE) ? req_bus.key : key_ff;

   // Row of cells with neighbour links.
   assign hit_chain[0] = 1'b0;
   assign pos_chain[0] = {IW{1'b0}};

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_W-1:0] left_entry;
      logic [KEY_W-1:0] right_entry;
      logic             right_match;

      if (g == 0) begin : g_front
         assign left_entry = {KEY_W{1'b0}};
      end else begin : g_inner
         assign left_entry = entry_bus[g-1];
      end

      if (g == CAPACITY - 1) begin : g_back
         assign right_entry = entry_bus[g];
         assign right_match = 1'b0;
      end else begin : g_body
         assign right_entry = entry_bus[g+1];
         assign right_match = match_bus[g+1];
      end

      tsol_cell #(
         .INDEX    (g),
         .CAPACITY (CAPACITY)
      ) u_cell (
         .clock       (clock),
         .key         (key_sel),
         .count       (count_ff),
         .capture     (capture),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .right_match (right_match),
         .hit_in      (hit_chain[g]),
         .pos_in      (pos_chain[g]),
         .entry       (entry_bus[g]),
         .match       (match_bus[g]),
         .hit_out     (hit_chain[g+1]),
         .pos_out     (pos_chain[g+1])
      );
   end

   assign found   = hit_chain[CAPACITY];
   assign hit_pos = pos_chain[CAPACITY];

   // Operation decode: status, position, new count and cell commands.
   always_comb begin
      status_in   = STATUS_NOT_FOUND;
      position_in = {POS_W{1'b0}};
      count_in    = count_ff;
      ctrl        = '0;
      unique case (action_ff)
         ACT_SEARCH: begin
            if (found) begin
               ctrl.transpose = commit;
               status_in      = STATUS_OK;
               position_in    = POS_W'(hit_pos);
            end
         end
         ACT_INSERT: begin
            if (found) begin
               ctrl.transpose = commit;
               status_in      = STATUS_DUPLICATE;
               position_in    = POS_W'(hit_pos);
            end else if (count_ff >= CW'(CAPACITY)) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.append = commit;
               status_in   = STATUS_OK;
               position_in = POS_W'(count_ff);
               count_in    = count_ff + CW'(1);
            end
         end
         ACT_REMOVE: begin
            if (found) begin
               ctrl.remove = commit;
               status_in   = STATUS_OK;
               position_in = POS_W'(hit_pos);
               count_in    = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = STATUS_NOT_FOUND;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= {CW{1'b0}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Transaction and response payload registers.
   always_ff @(posedge clock) begin
      if (capture) begin
         action_ff <= req_bus.action;
         key_ff    <= req_bus.key;
      end
      if (commit) begin
         status_ff      <= status_in;
         position_ff    <= position_in;
         entry_count_ff <= COUNT_W'(count_in);
         is_empty_ff    <= (count_in == {CW{1'b0}});
      end
   end

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.position    = position_ff;
   assign rsp_bus.entry_count = entry_count_ff;
   assign rsp_bus.is_empty    = is_empty_ff;

endmodule

>>> src/tsol_checker.sv
// ----------------------------------------------------------------------------
// Transpose self-organising list port checker
// Watches the request and response ports and checks their relationships.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "transpose_self_organizing_list_defines.svh"

module tsol_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tsol_pkg::STATUS_W-1:0] rsp_status,
   input logic [tsol_pkg::POS_W-1:0]    rsp_position,
   input logic [tsol_pkg::COUNT_W-1:0]  rsp_entry_count,
   input logic                          rsp_is_empty
);
   import tsol_pkg::*;

   // A transaction is always followed by an update cycle that takes no request.
   `TSOL_ASSERT_NEXT(a_update_gap, req_valid && req_ready, !req_ready, "request taken during update")

   // An empty list reports a zero count.
   `TSOL_ASSERT_IMPL(a_empty_count, rsp_valid && rsp_is_empty, rsp_entry_count == '0, "empty with count")

   // Failed operations report position zero.
   `TSOL_ASSERT_IMPL(a_fail_pos, rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_NOT_FOUND), rsp_position == '0, "failed with position")

   // A held response keeps its payload.
   `TSOL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_entry_count), "response changed while stalled")

endmodule

bind transpose_self_organizing_list tsol_checker u_tsol_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_position    (rsp_bus.position),
   .rsp_entry_count (rsp_bus.entry_count),
   .rsp_is_empty    (rsp_bus.is_empty)
);

>>> bench/transpose_self_organizing_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transpose self-organising list testbench
// Drives search, insert and remove transactions into the list and checks each
// response against a behavioural copy of the list kept in the bench. A short
// directed run fills, overflows and reorders the store. Random runs follow,
// with keys drawn mostly from a small pool so that hits, duplicates and a full
// store are common. The sender idles and the receiver stalls in turn.
// ----------------------------------------------------------------------------

module transpose_self_organizing_list_tb;
   import tsol_pkg::*;

   localparam int LIST_DEPTH     = 16;
   localparam int POOL_SIZE      = 24;
   localparam int HOLD_CYCLES    = 60;
   localparam int QUIET_LIMIT    = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int SETTLE_CYCLES  = 8;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // One response as the list should produce it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  entry_count;
      logic                is_empty;
   } list_reply_type;

   // Behavioural copy of the list, with the replies still owed by the block.
   class transpose_list_model;
      logic [KEY_W-1:0] keys [LIST_DEPTH];
      int               held;
      list_reply_type   owed_replies[$];
      int               errors;
      int               replies_checked;
      int               actions_seen [4];
      int               statuses_seen [4];

      function new();
         held = 0;
         errors = 0;
         replies_checked = 0;
         foreach (actions_seen[i]) actions_seen[i] = 0;
         foreach (statuses_seen[i]) statuses_seen[i] = 0;
      endfunction

      // Swap the entry at the given index with the one just ahead of it.
      function void move_forward(int at);
         logic [KEY_W-1:0] t;
         if (at > 0) begin
            t = keys[at];
            keys[at] = keys[at-1];
            keys[at-1] = t;
         end
      endfunction

      // Apply one accepted transaction and queue the reply it must cause.
      function void apply_operation(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k);
         list_reply_type r;
         int             hit;
         r.status   = STATUS_NOT_FOUND;
         r.position = '0;
         hit = -1;
         for (int j = 0; j < held; j++) begin
            if (hit < 0 && keys[j] == k) hit = j;
         end
         case (act)
            ACT_SEARCH: begin
               if (hit >= 0) begin
                  move_forward(hit);
                  r.status   = STATUS_OK;
                  r.position = hit[POS_W-1:0];
               end
            end
            ACT_INSERT: begin
               if (hit >= 0) begin
                  move_forward(hit);
                  r.status   = STATUS_DUPLICATE;
                  r.position = hit[POS_W-1:0];
               end else if (held >= LIST_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  keys[held] = k;
                  r.position = held[POS_W-1:0];
                  held++;
                  r.status = STATUS_OK;
               end
            end
            ACT_REMOVE: begin
               if (hit >= 0) begin
                  for (int j = hit; j + 1 < held; j++) keys[j] = keys[j+1];
                  held--;
                  r.status   = STATUS_OK;
                  r.position = hit[POS_W-1:0];
               end
            end
            default: begin
               // The unused code leaves the list alone.
            end
         endcase
         r.entry_count = held[COUNT_W-1:0];
         r.is_empty    = (held == 0);
         actions_seen[act]++;
         statuses_seen[r.status]++;
         owed_replies.push_back(r);
      endfunction

      // Compare one accepted response with the oldest owed reply.
      function void match_reply(list_reply_type got);
         list_reply_type want;
         if (owed_replies.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("response with no transaction outstanding: status %0d position %0d",
                        got.status, got.position);
            return;
         end
         want = owed_replies.pop_front();
         replies_checked++;
         if (got.status != want.status || got.position != want.position ||
             got.entry_count != want.entry_count || got.is_empty != want.is_empty) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("reply %0d wrong: expected status %0d position %0d count %0d empty %0d,%s",
                        replies_checked, want.status, want.position, want.entry_count,
                        want.is_empty, "");
            if (errors <= REPORT_LIMIT)
               $display("   got status %0d position %0d count %0d empty %0d",
                        got.status, got.position, got.entry_count, got.is_empty);
         end
      endfunction

      function int outstanding();
         return owed_replies.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   tsol_req_if req_bus ();
   tsol_rsp_if rsp_bus ();

   transpose_list_model model;
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];
   int                  send_idle_pct;
   int                  recv_stall_pct;
   int                  hold_asked;
   int                  hold_served = 0;
   int                  hold_left = 0;
   int                  quiet_cycles = 0;

   transpose_self_organizing_list #(
      .CAPACITY (LIST_DEPTH)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Free-running clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Response ready: random stalls, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor both channels and keep a watchdog on cycles without a transaction.
   always @(posedge clock) begin : channel_monitor
      list_reply_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status      = rsp_bus.status;
            got.position    = rsp_bus.position;
            got.entry_count = rsp_bus.entry_count;
            got.is_empty    = rsp_bus.is_empty;
            model.match_reply(got);
         end
         if (req_bus.valid && req_bus.ready)
            model.apply_operation(req_bus.action, req_bus.key);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Offer one transaction, after a random gap, and wait until it is taken.
   task automatic offer_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.key    <= k;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stop offering and wait until every owed reply has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (model.outstanding() != 0);
   endtask

   // New pool of keys for a phase, with the two signed extremes always in it.
   task automatic refresh_pool();
      foreach (key_pool[i]) key_pool[i] = $urandom();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
   endtask

   // Random transactions with the given insert and remove weights in percent.
   task automatic random_burst(input int n, input int insert_w, input int remove_w);
      int               pick;
      logic [ACTION_W-1:0] act;
      logic [KEY_W-1:0]    k;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 3) act = ACT_UNUSED;
         else if (pick < 3 + insert_w) act = ACT_INSERT;
         else if (pick < 3 + insert_w + remove_w) act = ACT_REMOVE;
         else act = ACT_SEARCH;
         if ($urandom_range(99) < 80) k = key_pool[$urandom_range(POOL_SIZE-1)];
         else k = $urandom();
         offer_request(act, k);
      end
   endtask

   // One idling phase: fill the list towards full, then thin it out again.
   task automatic run_phase(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      refresh_pool();
      random_burst(90, 55, 12);
      random_burst(90, 20, 45);
      wait_drained();
   endtask

   initial begin
      model = new();
      reset = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_SEARCH;
      req_bus.key    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asked     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: misses on an empty list and the unused code.
      offer_request(ACT_SEARCH, 32'h0000_0000);
      offer_request(ACT_REMOVE, 32'h0000_0005);
      offer_request(ACT_UNUSED, 32'hFFFF_FFFF);
      // Fill the store with the extremes and walking patterns, then overflow it.
      offer_request(ACT_INSERT, 32'h8000_0000);
      offer_request(ACT_INSERT, 32'h7FFF_FFFF);
      offer_request(ACT_INSERT, 32'h0000_0000);
      offer_request(ACT_INSERT, 32'hFFFF_FFFF);
      for (int i = 0; i < 12; i++) offer_request(ACT_INSERT, 32'h1 << (2 * i));
      offer_request(ACT_INSERT, 32'h1234_5678);
      // Duplicate insert still moves the key forward; a hit at the front stays put.
      offer_request(ACT_INSERT, 32'h7FFF_FFFF);
      offer_request(ACT_SEARCH, 32'h7FFF_FFFF);
      offer_request(ACT_SEARCH, 32'h0040_0000);
      // Removal from the middle and from the front.
      offer_request(ACT_REMOVE, 32'h0000_0000);
      offer_request(ACT_REMOVE, 32'h7FFF_FFFF);
      wait_drained();

      // Random phases under each idling pattern.
      run_phase(0, 0);
      run_phase(50, 0);
      run_phase(0, 50);
      run_phase(12, 12);

      // Back-pressure: the receiver holds off while the sender keeps offering.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      refresh_pool();
      hold_asked <= hold_asked + 1;
      random_burst(30, 40, 20);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      model.errors += model.outstanding();
      $display("covered %0d replies: %0d searches, %0d inserts, %0d removes, %0d unused codes",
               model.replies_checked, model.actions_seen[ACT_SEARCH],
               model.actions_seen[ACT_INSERT], model.actions_seen[ACT_REMOVE],
               model.actions_seen[ACT_UNUSED]);
      $display("outcomes: %0d ok, %0d not found, %0d duplicate, %0d store full; %0d failures",
               model.statuses_seen[STATUS_OK], model.statuses_seen[STATUS_NOT_FOUND],
               model.statuses_seen[STATUS_DUPLICATE], model.statuses_seen[STATUS_FULL],
               model.errors);
      if (model.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
